[hw/rtl/smms_pkg.sv]
package smms_pkg;

  localparam int unsigned CNT_W = 16;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             empty;
    logic             dropped;
    logic [CNT_W-1:0] count;
  } acc_stat_t;

endpackage

[hw/rtl/smms_acc.sv]
module smms_acc #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_LIMIT  = 65535
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          add_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                sample_i,
  output logic signed [SAMPLE_WIDTH-1:0]                min_o,
  output logic signed [SAMPLE_WIDTH-1:0]                max_o,
  output logic signed [SAMPLE_WIDTH+smms_pkg::CNT_W-1:0] sum_o,
  output logic [2*SAMPLE_WIDTH+smms_pkg::CNT_W-1:0]     sumsq_o,
  output smms_pkg::acc_stat_t                           stat_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned CW    = smms_pkg::CNT_W;
  localparam int unsigned SUM_W = SW + CW;
  localparam int unsigned SQ_W  = 2 * SW + CW;

  logic signed [SW-1:0]    min_q, max_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sumsq_q;
  logic [CW-1:0]           count_q;
  logic                    dropped_q;
  logic                    full;
  logic signed [2*SW-1:0]  sq;

  assign full = count_q >= CW'(COUNT_LIMIT);
  assign sq   = sample_i * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= {1'b0, {(SW-1){1'b1}}};
      max_q     <= {1'b1, {(SW-1){1'b0}}};
      sum_q     <= '0;
      sumsq_q   <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else if (add_i) begin
      if (full) begin
        dropped_q <= 1'b1;
      end else begin
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
        sum_q   <= sum_q + SUM_W'(sample_i);
        sumsq_q <= sumsq_q + SQ_W'($unsigned(sq));
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign min_o          = min_q;
  assign max_o          = max_q;
  assign sum_o          = sum_q;
  assign sumsq_o        = sumsq_q;
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.dropped = dropped_q;
  assign stat_o.count   = count_q;

endmodule

[hw/rtl/smms_mul.sv]
module smms_mul #(
  parameter int unsigned A_W = 48,
  parameter int unsigned B_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               busy_o,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int unsigned P_W = A_W + B_W;

  logic [B_W-1:0] mplier_q;
  logic [P_W-1:0] acc_q, mcand_q;

  // one multiplier bit per cycle, stops early once the remaining bits are zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
    end else if (start_i) begin
      mplier_q <= b_i;
    end else if (busy_o) begin
      mplier_q <= mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= P_W'(a_i);
    end else if (busy_o) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q <= mcand_q << 1;
    end
  end

  assign busy_o = |mplier_q;
  assign p_o    = acc_q;

endmodule

[hw/rtl/smms_sqrt.sv]
module smms_sqrt #(
  parameter int unsigned N_W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [N_W-1:0]     rad_i,
  output logic               busy_o,
  output logic [N_W/2-1:0]   root_o
);

  localparam int unsigned R_W = N_W / 2;
  localparam int unsigned C_W = $clog2(R_W + 1);

  logic [C_W-1:0] step_q;
  logic [N_W-1:0] rad_q;
  logic [R_W+1:0] rem_q;
  logic [R_W-1:0] root_q;
  logic [R_W+3:0] shifted, trial, diff;
  logic           ge;

  // restoring root: two radicand bits in, one root bit out per cycle
  assign shifted = {rem_q, rad_q[N_W-1:N_W-2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = shifted >= trial;
  assign diff    = shifted - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= C_W'(R_W);
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_o) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[R_W+1:0] : shifted[R_W+1:0];
      root_q <= {root_q[R_W-2:0], ge};
    end
  end

  assign busy_o = (step_q != '0);
  assign root_o = root_q;

endmodule

[hw/rtl/smms_div.sv]
module smms_div #(
  parameter int unsigned D_W = 32,
  parameter int unsigned V_W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [D_W-1:0] dividend_i,
  input  logic [V_W-1:0] divisor_i,
  output logic           busy_o,
  output logic [D_W-1:0] quot_o
);

  localparam int unsigned C_W = $clog2(D_W + 1);

  logic [C_W-1:0] step_q;
  logic [D_W-1:0] quo_q;
  logic [V_W-1:0] rem_q, dvs_q;
  logic [V_W:0]   sh, diff;
  logic           ge;

  // restoring divide, one quotient bit per cycle shifted into the dividend register
  assign sh   = {rem_q, quo_q[D_W-1]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= C_W'(D_W);
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      quo_q <= {quo_q[D_W-2:0], ge};
      rem_q <= ge ? diff[V_W-1:0] : sh[V_W-1:0];
    end
  end

  assign busy_o = (step_q != '0);
  assign quot_o = quo_q;

endmodule

[hw/rtl/stream_min_max_mean_stddev.sv]
// Add beats: a new beat every cycle while idle.
// Report beat on an empty stream: goes straight to ST_OUT, skipping the arithmetic.
// Report beat otherwise: the mean divide runs beside the bit-serial multiplies (ST_MUL), then the
// square root (ST_SQRT) and the deviation divide (ST_DIV), then ST_OUT; no input is taken meanwhile.
// A finished result waits in the output register while new beats are accepted.
// rst_ni (async, active low) empties the statistics and drops any pending result.
module stream_min_max_mean_stddev #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_LIMIT  = 65535
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] minimum_o,
  output logic signed [SAMPLE_WIDTH-1:0] maximum_o,
  output logic signed [SAMPLE_WIDTH-1:0] average_o,
  output logic [SAMPLE_WIDTH-2:0]        deviation_o,
  output logic [smms_pkg::CNT_W-1:0]     sample_count_o,
  output logic                           overflowed_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned CW    = smms_pkg::CNT_W;
  localparam int unsigned SUM_W = SW + CW;
  localparam int unsigned SQ_W  = 2 * SW + CW;
  localparam int unsigned P_W   = 2 * SUM_W;

  smms_pkg::state_e    state_q, state_d;
  smms_pkg::acc_stat_t stat;

  logic signed [SW-1:0]    acc_min, acc_max;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]         acc_sumsq;
  logic [SUM_W-1:0]        sum_u, sum_mag;
  logic                    sum_neg;
  logic                    accept, add;

  logic             mul_start, sqrt_start, div_start;
  logic             mul_a_busy, mul_b_busy, sqrt_busy, div_busy;
  logic [P_W-1:0]   prod_a, prod_b, rad;
  logic [SUM_W-1:0] root, div_dividend, div_quot;
  logic [SW-1:0]    quot_trunc;

  logic res_clr, avg_ld, dev_ld, out_ld;

  logic signed [SW-1:0] avg_q;
  logic [SW-2:0]        dev_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] minimum_q, maximum_q, average_q;
  logic [SW-2:0]        deviation_q;
  logic [CW-1:0]        count_q;
  logic                 overflowed_q;

  assign in_ready_o = (state_q == smms_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign add        = accept && (command_i == smms_pkg::CMD_ADD);

  smms_acc #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .add_i   (add),
    .sample_i(sample_i),
    .min_o   (acc_min),
    .max_o   (acc_max),
    .sum_o   (acc_sum),
    .sumsq_o (acc_sumsq),
    .stat_o  (stat)
  );

  assign sum_u   = $unsigned(acc_sum);
  assign sum_neg = acc_sum[SUM_W-1];
  assign sum_mag = sum_neg ? (~sum_u + 1'b1) : sum_u;

  // count * sumsq
  smms_mul #(
    .A_W(SQ_W),
    .B_W(CW)
  ) u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (acc_sumsq),
    .b_i    (stat.count),
    .busy_o (mul_a_busy),
    .p_o    (prod_a)
  );

  // sum^2
  smms_mul #(
    .A_W(SUM_W),
    .B_W(SUM_W)
  ) u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (sum_mag),
    .b_i    (sum_mag),
    .busy_o (mul_b_busy),
    .p_o    (prod_b)
  );

  assign rad = (prod_a >= prod_b) ? (prod_a - prod_b) : '0;

  smms_sqrt #(
    .N_W(P_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .rad_i  (rad),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  // shared divider: |sum| / count during the multiply, then root / count
  assign div_dividend = (state_q == smms_pkg::ST_IDLE) ? sum_mag : root;

  smms_div #(
    .D_W(SUM_W),
    .V_W(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (stat.count),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  assign quot_trunc = div_quot[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    res_clr    = 1'b0;
    avg_ld     = 1'b0;
    dev_ld     = 1'b0;
    out_ld     = 1'b0;
    unique case (state_q)
      smms_pkg::ST_IDLE: begin
        if (accept && command_i == smms_pkg::CMD_REPORT) begin
          res_clr = 1'b1;
          if (stat.empty) begin
            state_d = smms_pkg::ST_OUT;
          end else begin
            mul_start = 1'b1;
            div_start = 1'b1;
            state_d   = smms_pkg::ST_MUL;
          end
        end
      end
      smms_pkg::ST_MUL: begin
        if (!mul_a_busy && !mul_b_busy && !div_busy) begin
          avg_ld     = 1'b1;
          sqrt_start = 1'b1;
          state_d    = smms_pkg::ST_SQRT;
        end
      end
      smms_pkg::ST_SQRT: begin
        if (!sqrt_busy) begin
          div_start = 1'b1;
          state_d   = smms_pkg::ST_DIV;
        end
      end
      smms_pkg::ST_DIV: begin
        if (!div_busy) begin
          dev_ld  = 1'b1;
          state_d = smms_pkg::ST_OUT;
        end
      end
      smms_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld  = 1'b1;
          state_d = smms_pkg::ST_IDLE;
        end
      end
      default: state_d = smms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_clr) begin
      avg_q <= '0;
      dev_q <= '0;
    end else begin
      if (avg_ld) avg_q <= sum_neg ? -$signed(quot_trunc) : $signed(quot_trunc);
      if (dev_ld) dev_q <= div_quot[SW-2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      minimum_q    <= acc_min;
      maximum_q    <= acc_max;
      average_q    <= avg_q;
      deviation_q  <= dev_q;
      count_q      <= stat.count;
      overflowed_q <= stat.dropped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign minimum_o      = minimum_q;
  assign maximum_o      = maximum_q;
  assign average_o      = average_q;
  assign deviation_o    = deviation_q;
  assign sample_count_o = count_q;
  assign overflowed_o   = overflowed_q;

  a_empty_report_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == smms_pkg::CMD_REPORT && stat.empty)
      |=> state_q == smms_pkg::ST_OUT)
    else $error("empty report did not go straight to output");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_count_o == '0) |-> (average_o == '0 && deviation_o == '0))
    else $error("empty result has nonzero mean or deviation");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> sample_count_o == stat.count)
    else $error("reported count differs from accumulator");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.empty |-> acc_min <= acc_max)
    else $error("running min above running max");

  a_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(stat.dropped) |-> stat.dropped)
    else $error("drop flag cleared without reset");

endmodule
